[hw/rtl/fpba_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpba_pkg
// Shared types and codes of the fit-policy block allocator.
// ----------------------------------------------------------------------------
package fpba_pkg;

	localparam int IDX_W      = 7;
	localparam int SIZE_W     = 16;
	localparam int OWNER_W    = 8;
	localparam int COUNT_W    = 8;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;

	typedef enum logic [1:0] {
		ACT_LOAD  = 2'd0,
		ACT_ALLOC = 2'd1,
		ACT_READ  = 2'd2,
		ACT_CLEAR = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		FIT_FIRST = 2'd0,
		FIT_BEST  = 2'd1,
		FIT_NEXT  = 2'd2,
		FIT_WORST = 2'd3
	} fit_mode_t;

	localparam logic [CFG_IDX_W-1:0] REG_FIT_MODE    = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 1'd1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MOD,
		ST_SCAN,
		ST_WRITE,
		ST_RDWAIT,
		ST_RESP
	} state_t;

	typedef struct packed {
		action_t              action;
		logic [IDX_W-1:0]     block_index;
		logic [SIZE_W-1:0]    block_size_value;
		logic [SIZE_W-1:0]    request_size;
		logic [OWNER_W-1:0]   owner_id;
	} in_word_t;

	typedef struct packed {
		logic                 granted;
		logic [IDX_W-1:0]     chosen_index;
		logic [SIZE_W-1:0]    size_read;
		logic [OWNER_W-1:0]   owner_read;
	} out_word_t;

endpackage

[hw/rtl/fit_policy_block_allocator_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fit_policy_block_allocator_top
// Block table with first, best, next and worst fit allocation.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | word
//  in      | input     | in_valid/in_ready  | action, index, size, request, owner
//  out     | output    | out_valid/out_ready| granted, index, size, owner
//  cfg     | input     | cfg_valid/cfg_ready| register index, data (always ready)
//
// load writes the entry, read goes through the registered table read, and free all
// runs a clearing pass over the owner table. allocate scans n entries, n = min(block_count,
// MAX_BLOCKS); next fit first reckons its start position, the last placed index
// modulo n, as a restoring remainder. The scan reads one table entry per cycle through a single read port.
// after reset a clearing pass over all MAX_BLOCKS entries frees the owner table;
// in_ready stays low meanwhile. one item is in work at a time; the next is
// taken while the previous word waits in the output register.
module fit_policy_block_allocator_top #(
	parameter int MAX_BLOCKS = 128
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  fpba_pkg::in_word_t                 in_data,
	output logic                               out_valid,
	input  logic                               out_ready,
	output fpba_pkg::out_word_t                out_data,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [fpba_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [fpba_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import fpba_pkg::*;

	localparam int IW = $clog2(MAX_BLOCKS);
	localparam int CW = $clog2(MAX_BLOCKS + 1);
	localparam int NW = (CW > COUNT_W) ? CW : COUNT_W;
	localparam int XW = (IW > IDX_W) ? IW : IDX_W;
	localparam int DW = IW + CW;
	localparam int KW = $clog2(IW + 1);

	// table memories
	logic [SIZE_W-1:0]  size_mem  [MAX_BLOCKS];
	logic [OWNER_W-1:0] owner_mem [MAX_BLOCKS];
	logic [SIZE_W-1:0]  size_rd_q;
	logic [OWNER_W-1:0] owner_rd_q;

	// control and datapath registers
	state_t             state_q, state_d;
	fit_mode_t          fit_mode_q;
	logic [COUNT_W-1:0] block_count_q;
	in_word_t           item_q;
	logic               in_ok_q;
	out_word_t          res_q;
	out_word_t          out_q;
	logic               out_valid_q;
	logic               clr_resp_q;
	logic [IW-1:0]      clr_cnt_q;
	logic [IW-1:0]      pos_q;
	logic [IW-1:0]      rem_q;
	logic [KW-1:0]      k_q;
	logic [IW-1:0]      addr_q;
	logic [CW-1:0]      iss_cnt_q;
	logic               chk_v_s1;
	logic [IW-1:0]      chk_idx_s1;
	logic               found_q;
	logic [IW-1:0]      pick_q;
	logic [SIZE_W-1:0]  best_q;

	// combinational signals
	logic               rd_en;
	logic [IW-1:0]      rd_addr;
	logic               sz_we;
	logic               ow_we;
	logic [IW-1:0]      ow_wa;
	logic [OWNER_W-1:0] ow_wd;
	logic [NW-1:0]      bc_ext;
	logic [CW-1:0]      n_act;
	logic [XW-1:0]      in_idx_x;
	logic [IW-1:0]      in_addr;
	logic               in_range;
	logic               in_acc;
	logic [DW-1:0]      mod_sub;
	logic               mod_ge;
	logic [IW-1:0]      rem_nx;
	logic               issue;
	logic [IW:0]        addr_inc;
	logic [IW-1:0]      addr_nx;
	logic               fits;
	logic               take;
	logic               stop_first;
	logic               scan_end;
	logic               clr_last;
	logic               resp_go;
	logic [XW-1:0]      pick_x;

	assign bc_ext   = NW'(block_count_q);
	assign n_act    = (bc_ext > NW'(MAX_BLOCKS)) ? CW'(MAX_BLOCKS) : CW'(bc_ext);
	assign in_idx_x = XW'(in_data.block_index);
	assign in_addr  = in_idx_x[IW-1:0];
	assign in_range = (32'(in_data.block_index) < MAX_BLOCKS);
	assign in_acc   = in_valid && in_ready;

	// restoring remainder, one quotient bit per cycle
	assign mod_sub = DW'(n_act) << k_q;
	assign mod_ge  = (DW'(rem_q) >= mod_sub);
	assign rem_nx  = mod_ge ? IW'(DW'(rem_q) - mod_sub) : rem_q;

	assign issue    = (state_q == ST_SCAN) && (iss_cnt_q != n_act);
	assign addr_inc = {1'b0, addr_q} + 1'b1;
	assign addr_nx  = (addr_inc == (IW + 1)'(n_act)) ? '0 : addr_inc[IW-1:0];

	// best and worst compare sizes, since the request is the same for all
	assign fits = chk_v_s1 && (owner_rd_q == '0) && (size_rd_q >= item_q.request_size);
	assign take = fits && (!found_q ||
		(fit_mode_q == FIT_BEST && size_rd_q < best_q) ||
		(fit_mode_q == FIT_WORST && size_rd_q > best_q));
	assign stop_first = fits && (fit_mode_q == FIT_FIRST || fit_mode_q == FIT_NEXT);
	assign scan_end   = (iss_cnt_q == n_act) && !chk_v_s1;
	assign clr_last   = (clr_cnt_q == IW'(MAX_BLOCKS - 1));
	assign resp_go    = (state_q == ST_RESP) && (!out_valid_q || out_ready);
	assign pick_x     = XW'(pick_q);

	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		rd_en    = 1'b0;
		rd_addr  = addr_q;
		sz_we    = 1'b0;
		ow_we    = 1'b0;
		ow_wa    = in_addr;
		ow_wd    = '0;
		case (state_q)
			ST_CLEAR: begin
				ow_we = 1'b1;
				ow_wa = clr_cnt_q;
				if (clr_last) begin
					state_d = clr_resp_q ? ST_RESP : ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					case (in_data.action)
						ACT_LOAD: begin
							sz_we   = in_range;
							ow_we   = in_range;
							state_d = ST_RESP;
						end
						ACT_ALLOC: begin
							if (n_act == '0) begin
								state_d = ST_RESP;
							end else if (fit_mode_q == FIT_NEXT) begin
								state_d = ST_MOD;
							end else begin
								state_d = ST_SCAN;
							end
						end
						ACT_READ: begin
							rd_en   = 1'b1;
							rd_addr = in_addr;
							state_d = ST_RDWAIT;
						end
						ACT_CLEAR: begin
							state_d = ST_CLEAR;
						end
						default: begin
							state_d = ST_RESP;
						end
					endcase
				end
			end
			ST_MOD: begin
				if (k_q == '0) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				rd_en = issue;
				if (stop_first) begin
					state_d = ST_WRITE;
				end else if (scan_end) begin
					state_d = found_q ? ST_WRITE : ST_RESP;
				end
			end
			ST_WRITE: begin
				ow_we   = 1'b1;
				ow_wa   = pick_q;
				ow_wd   = item_q.owner_id;
				state_d = ST_RESP;
			end
			ST_RDWAIT: begin
				state_d = ST_RESP;
			end
			ST_RESP: begin
				if (resp_go) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// memories: one write port each, shared registered read
	always_ff @(posedge clk) begin
		if (sz_we) begin
			size_mem[in_addr] <= in_data.block_size_value;
		end
		if (ow_we) begin
			owner_mem[ow_wa] <= ow_wd;
		end
		if (rd_en) begin
			size_rd_q  <= size_mem[rd_addr];
			owner_rd_q <= owner_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_mode_q    <= FIT_FIRST;
			block_count_q <= COUNT_W'(128);
			item_q        <= '0;
			in_ok_q       <= 1'b0;
			res_q         <= '0;
			out_q         <= '0;
			out_valid_q   <= 1'b0;
			clr_resp_q    <= 1'b0;
			clr_cnt_q     <= '0;
			pos_q         <= '0;
			rem_q         <= '0;
			k_q           <= '0;
			addr_q        <= '0;
			iss_cnt_q     <= '0;
			chk_v_s1      <= 1'b0;
			chk_idx_s1    <= '0;
			found_q       <= 1'b0;
			pick_q        <= '0;
			best_q        <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_FIT_MODE:    fit_mode_q    <= fit_mode_t'(cfg_data[1:0]);
					REG_BLOCK_COUNT: block_count_q <= cfg_data;
					default: ;
				endcase
			end

			if (resp_go) begin
				out_q       <= res_q;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					pos_q     <= '0;
				end
				ST_IDLE: begin
					if (in_acc) begin
						item_q           <= in_data;
						in_ok_q          <= in_range;
						res_q            <= '0;
						res_q.granted    <= !(in_data.action == ACT_ALLOC && n_act == '0);
						clr_cnt_q        <= '0;
						clr_resp_q       <= 1'b1;
						rem_q            <= pos_q;
						k_q              <= KW'(IW - 1);
						addr_q           <= '0;
						iss_cnt_q        <= '0;
						chk_v_s1         <= 1'b0;
						found_q          <= 1'b0;
					end
				end
				ST_MOD: begin
					rem_q <= rem_nx;
					k_q   <= k_q - 1'b1;
					if (k_q == '0) begin
						addr_q <= rem_nx;
					end
				end
				ST_SCAN: begin
					chk_v_s1   <= issue;
					chk_idx_s1 <= addr_q;
					if (issue) begin
						addr_q    <= addr_nx;
						iss_cnt_q <= iss_cnt_q + 1'b1;
					end
					if (take) begin
						found_q <= 1'b1;
						pick_q  <= chk_idx_s1;
						best_q  <= size_rd_q;
					end
					if (!stop_first && scan_end && !found_q) begin
						res_q.granted <= 1'b0;
					end
				end
				ST_WRITE: begin
					pos_q              <= pick_q;
					res_q.granted      <= 1'b1;
					res_q.chosen_index <= pick_x[IDX_W-1:0];
				end
				ST_RDWAIT: begin
					res_q.chosen_index <= item_q.block_index;
					res_q.size_read    <= in_ok_q ? size_rd_q : '0;
					res_q.owner_read   <= in_ok_q ? owner_rd_q : '0;
				end
				default: ;
			endcase
		end
	end

endmodule

[hw/rtl/fpba_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpba_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module fpba_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic                               in_ready,
	input  logic                               out_valid,
	input  logic                               out_ready,
	input  fpba_pkg::out_word_t                out_data,
	input  logic                               cfg_valid,
	input  logic                               cfg_ready,
	input  logic [fpba_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [fpba_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import fpba_pkg::*;

	logic [1:0] pend_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// items taken whose words are not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 2'(in_acc) - 2'(out_acc);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output word changed while stalled");

	a_no_extra_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 2'd0)
		else $error("output word without an item taken");

	a_two_max: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q == 2'd2 |-> !in_acc)
		else $error("item taken with two words outstanding");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.granted |->
			out_data.chosen_index == '0 && out_data.size_read == '0 &&
			out_data.owner_read == '0)
		else $error("failed allocate carries nonzero fields");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready && !$isunknown({cfg_index, cfg_data}))
		else $error("configuration write refused or unknown");

endmodule

bind fit_policy_block_allocator_top fpba_checker u_fpba_checker (.*);

[test/fit_policy_block_allocator_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fit_policy_block_allocator_top_test
// Checks the block allocator against a predictor of its table under all four
// fit policies and a range of block counts. A directed opening is followed by
// random traffic, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module fit_policy_block_allocator_top_test;
	import fpba_pkg::*;

	localparam int MAX_BLOCKS = 128;
	localparam int LIMIT_NS   = 10_000_000;
	localparam int LONG_HOLD  = 400;
	localparam int PLAN_LEN   = 13;

	localparam fit_mode_t PLAN_MODE [PLAN_LEN] = '{
		FIT_FIRST, FIT_BEST, FIT_NEXT, FIT_WORST, FIT_NEXT, FIT_FIRST, FIT_BEST,
		FIT_WORST, FIT_NEXT, FIT_BEST, FIT_FIRST, FIT_WORST, FIT_NEXT
	};
	localparam int PLAN_COUNT [PLAN_LEN] = '{8, 16, 128, 255, 5, 0, 1, 2, 200, 128, 128, 40, 3};
	localparam int PLAN_ITEMS [PLAN_LEN] = '{80, 100, 150, 80, 100, 30, 60, 60, 80, 80, 60, 60, 60};

	class alloc_scoreboard;
		logic [SIZE_W-1:0]  sizes [MAX_BLOCKS];
		logic [OWNER_W-1:0] owners [MAX_BLOCKS];
		bit                 written [MAX_BLOCKS];
		logic [IDX_W-1:0]   next_pos;
		fit_mode_t          mode;
		logic [COUNT_W-1:0] count;
		out_word_t          expected_q [$];
		int unsigned        mismatches;
		int unsigned        grants;
		int unsigned        refusals;
		int unsigned        results_seen;

		function new();
			for (int b = 0; b < MAX_BLOCKS; b++) begin
				sizes[b] = '0;
				owners[b] = '0;
				written[b] = 1'b0;
			end
			next_pos = '0;
			mode = FIT_FIRST;
			count = COUNT_W'(MAX_BLOCKS);
			mismatches = 0;
			grants = 0;
			refusals = 0;
			results_seen = 0;
		endfunction

		function int unsigned span();
			return (count > MAX_BLOCKS) ? MAX_BLOCKS : int'(count);
		endfunction

		function bit fits(int unsigned b, logic [SIZE_W-1:0] need);
			return owners[b] == '0 && sizes[b] >= need;
		endfunction

		function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
			if (idx == REG_FIT_MODE) begin
				mode = fit_mode_t'(value[1:0]);
			end else begin
				count = value;
			end
		endfunction

		function void note_input(in_word_t w);
			out_word_t   r;
			int          pick;
			int unsigned n;
			int unsigned b;
			int unsigned waste;
			int unsigned pick_waste;
			r = '0;
			r.granted = 1'b1;
			n = span();
			pick = -1;
			pick_waste = 0;
			case (w.action)
			ACT_LOAD: begin
				sizes[w.block_index] = w.block_size_value;
				owners[w.block_index] = '0;
				written[w.block_index] = 1'b1;
			end
			ACT_ALLOC: begin
				if (n != 0 && mode == FIT_NEXT) begin
					// circular scan from the last placed block
					for (int unsigned k = 0; k < n; k++) begin
						b = (next_pos % n + k) % n;
						if (fits(b, w.request_size)) begin
							pick = b;
							break;
						end
					end
				end else if (n != 0) begin
					for (b = 0; b < n; b++) begin
						if (!fits(b, w.request_size)) continue;
						waste = sizes[b] - w.request_size;
						if (mode == FIT_FIRST) begin
							pick = b;
							break;
						end
						// ties keep the lower index
						if (pick < 0 || (mode == FIT_BEST && waste < pick_waste) ||
								(mode == FIT_WORST && waste > pick_waste)) begin
							pick = b;
							pick_waste = waste;
						end
					end
				end
				if (pick < 0) begin
					r.granted = 1'b0;
					refusals++;
				end else begin
					owners[pick] = w.owner_id;
					next_pos = IDX_W'(pick);
					r.chosen_index = IDX_W'(pick);
					grants++;
				end
			end
			ACT_READ: begin
				r.chosen_index = w.block_index;
				r.size_read = sizes[w.block_index];
				r.owner_read = owners[w.block_index];
			end
			default: begin
				for (int i = 0; i < MAX_BLOCKS; i++) owners[i] = '0;
				next_pos = '0;
			end
			endcase
			expected_q.push_back(r);
		endfunction

		task report_mismatch(string what);
			mismatches++;
			if (mismatches <= 50) $display("mismatch at %0t ns: %s", $time, what);
		endtask

		task check_result(out_word_t got);
			out_word_t want;
			results_seen++;
			if (expected_q.size() == 0) begin
				report_mismatch($sformatf("result word %h with none expected", got));
				return;
			end
			want = expected_q.pop_front();
			if (got.granted !== want.granted)
				report_mismatch($sformatf("granted %b, expected %b", got.granted, want.granted));
			if (got.chosen_index !== want.chosen_index)
				report_mismatch($sformatf("chosen_index %0d, expected %0d",
					got.chosen_index, want.chosen_index));
			if (got.size_read !== want.size_read)
				report_mismatch($sformatf("size_read %0d, expected %0d",
					got.size_read, want.size_read));
			if (got.owner_read !== want.owner_read)
				report_mismatch($sformatf("owner_read %0d, expected %0d",
					got.owner_read, want.owner_read));
		endtask
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_ready;
	in_word_t               in_data;
	logic                   out_valid;
	logic                   out_ready;
	out_word_t              out_data;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	alloc_scoreboard sb = new();
	bit              idle_on = 1'b1;
	int unsigned     hold_cycles = 0;
	int unsigned     long_holds = 0;

	fit_policy_block_allocator_top #(
		.MAX_BLOCKS(MAX_BLOCKS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (!idle_on || r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic in_word_t mk(action_t a, int unsigned idx, int unsigned size_value,
			int unsigned need, int unsigned owner);
		in_word_t w;
		w.action = a;
		w.block_index = IDX_W'(idx);
		w.block_size_value = SIZE_W'(size_value);
		w.request_size = SIZE_W'(need);
		w.owner_id = OWNER_W'(owner);
		return w;
	endfunction

	function automatic in_word_t random_word();
		in_word_t    w;
		int unsigned n;
		int unsigned sel;
		int unsigned j;
		n = sb.span();
		w.block_index = IDX_W'($urandom);
		w.block_size_value = SIZE_W'($urandom);
		w.request_size = SIZE_W'($urandom);
		w.owner_id = ($urandom_range(0, 15) == 0) ? '0 : OWNER_W'($urandom_range(1, 255));
		sel = $urandom_range(0, 99);
		if (sel < 25) w.action = ACT_LOAD;
		else if (sel < 70) w.action = ACT_ALLOC;
		else if (sel < 95) w.action = ACT_READ;
		else w.action = ACT_CLEAR;

		// every block in the scan range must hold a loaded size first
		if (w.action == ACT_ALLOC) begin
			for (int unsigned b = 0; b < n; b++) begin
				if (!sb.written[b]) begin
					w.action = ACT_LOAD;
					w.block_index = IDX_W'(b);
					break;
				end
			end
		end
		if (w.action == ACT_READ && !sb.written[w.block_index]) w.action = ACT_LOAD;

		sel = $urandom_range(0, 9);
		j = $urandom_range(0, MAX_BLOCKS - 1);
		if (w.action == ACT_LOAD) begin
			if (n != 0 && $urandom_range(0, 3) != 0 && sb.written[n - 1])
				w.block_index = IDX_W'($urandom_range(0, n - 1));
			if (sel == 2) w.block_size_value = $urandom_range(0, 1) ? '1 : '0;
			else if (sel == 3 && sb.written[j]) w.block_size_value = sb.sizes[j];
			else if (sel > 3) w.block_size_value = SIZE_W'($urandom_range(0, 1023));
		end else if (w.action == ACT_ALLOC) begin
			if (n != 0) j = $urandom_range(0, n - 1);
			if (sel == 0) w.request_size = '0;
			else if (sel < 3 && n != 0) w.request_size = sb.sizes[j];
			else if (sel < 5 && n != 0) w.request_size = sb.sizes[j] >> 1;
			else if (sel > 5) w.request_size = SIZE_W'($urandom_range(0, 1023));
		end
		return w;
	endfunction

	task automatic push_word(input in_word_t w, input int unsigned gap);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_input(w);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.note_config(idx, value);
		@(negedge clk);
	endtask

	task automatic settle(input int unsigned cycles);
		while (sb.expected_q.size() != 0) @(negedge clk);
		repeat (cycles) @(negedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) sb.check_result(out_data);
	end

	// receiver side: random stalls plus the long hold-off on request
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_cycles != 0) begin
				out_ready <= 1'b0;
				repeat (hold_cycles) @(negedge clk);
				hold_cycles = 0;
				long_holds++;
			end else if (idle_on && $urandom_range(0, 99) < 30) begin
				out_ready <= 1'b0;
				repeat (1 + pick_gap()) @(negedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		write_reg(REG_FIT_MODE, CFG_DATA_W'(FIT_FIRST));
		write_reg(REG_BLOCK_COUNT, CFG_DATA_W'(4));
		cfg_valid <= 1'b0;

		// directed opening: four blocks in the scan range, one far outside it
		push_word(mk(ACT_LOAD, 0, 0, 0, 0), pick_gap());
		push_word(mk(ACT_LOAD, 1, 100, 0, 0), pick_gap());
		push_word(mk(ACT_LOAD, 2, 65535, 0, 0), pick_gap());
		push_word(mk(ACT_LOAD, 3, 100, 0, 0), pick_gap());
		push_word(mk(ACT_READ, 2, 0, 0, 0), pick_gap());
		push_word(mk(ACT_ALLOC, 0, 0, 0, 255), pick_gap());       // zero request takes size 0
		push_word(mk(ACT_ALLOC, 0, 0, 65535, 1), pick_gap());
		push_word(mk(ACT_ALLOC, 0, 0, 65535, 2), pick_gap());     // nothing fits
		push_word(mk(ACT_ALLOC, 0, 0, 50, 0), pick_gap());        // owner zero leaves it free
		push_word(mk(ACT_ALLOC, 0, 0, 50, 7), pick_gap());
		push_word(mk(ACT_READ, 1, 0, 0, 0), pick_gap());
		push_word(mk(ACT_READ, 0, 0, 0, 0), pick_gap());
		push_word(mk(ACT_LOAD, 127, 65535, 0, 0), pick_gap());
		push_word(mk(ACT_READ, 127, 0, 0, 0), pick_gap());
		push_word(mk(ACT_LOAD, 1, 7, 0, 0), pick_gap());          // load frees an owned block
		push_word(mk(ACT_READ, 1, 0, 0, 0), pick_gap());
		push_word(mk(ACT_CLEAR, 0, 0, 0, 0), pick_gap());
		push_word(mk(ACT_READ, 2, 0, 0, 0), pick_gap());          // sizes survive the clear
		push_word(mk(ACT_ALLOC, 0, 0, 1, 128), pick_gap());
		in_valid <= 1'b0;

		for (int p = 0; p < PLAN_LEN; p++) begin
			settle(8);
			idle_on = (p % 3 != 2);
			write_reg(REG_FIT_MODE, CFG_DATA_W'(PLAN_MODE[p]));
			write_reg(REG_BLOCK_COUNT, CFG_DATA_W'(PLAN_COUNT[p]));
			cfg_valid <= 1'b0;
			if (p == 2 || p == 9) hold_cycles = LONG_HOLD;
			for (int i = 0; i < PLAN_ITEMS[p]; i++) push_word(random_word(), pick_gap());
			in_valid <= 1'b0;
		end

		settle(MAX_BLOCKS + 16);
		$display("summary: %0d result words over %0d register settings, %0d grants, %0d refusals",
			sb.results_seen, PLAN_LEN + 1, sb.grants, sb.refusals);
		$display("summary: all four fit policies, block counts 0 to 255, %0d long output holds",
			long_holds);
		if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	initial begin
		#(LIMIT_NS);
		$display("timeout with %0d results outstanding", sb.expected_q.size());
		$display("FAILED: results differ");
		$finish;
	end

endmodule
